// File: hdl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared types and constants for the point to segment distance block
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int MSL_WIDTH  = 16;
    localparam int DIST_WIDTH = 33;
    localparam logic [MSL_WIDTH-1:0] MSL_RESET = 16'd7;

    typedef enum logic [1:0] {
        CASE_DEGEN = 2'd0,
        CASE_END   = 2'd1,
        CASE_START = 2'd2,
        CASE_PERP  = 2'd3
    } case_code_t;

endpackage

// File: hdl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// difference vectors, squared lengths, case decision and the squared cross
// product, five register stages
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int CW = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [CW-1:0]             px,
    input  logic signed [CW-1:0]             py,
    input  logic signed [CW-1:0]             sx,
    input  logic signed [CW-1:0]             sy,
    input  logic signed [CW-1:0]             ex,
    input  logic signed [CW-1:0]             ey,
    input  logic [psd_pkg::MSL_WIDTH-1:0]    msl,
    output logic                             out_valid,
    output psd_pkg::case_code_t              out_code,
    output logic [4*(CW+1)-1:0]              out_num,
    output logic [2*(CW+1):0]                out_den
);
    import psd_pkg::*;

    localparam int M    = CW + 1;
    localparam int SQ   = 2 * M;
    localparam int A2W  = 2 * M + 1;
    localparam int NUMW = 4 * M;
    localparam int LIMW = 2 * MSL_WIDTH;

    // stage 1: differences
    logic              s1_valid_reg;
    logic signed [M-1:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic [LIMW-1:0]   lim1_reg;

    // stage 2: squares and cross terms
    logic              s2_valid_reg;
    logic [A2W-1:0]    a2_reg, b2_reg, c2_reg;
    logic [SQ-1:0]     t1_reg, t2_reg;
    logic              mixed_reg;
    logic [LIMW-1:0]   lim2_reg;

    // stage 3: decision
    logic              s3_valid_reg;
    case_code_t        s3_code_reg;
    logic [SQ-1:0]     cr_reg;
    logic [A2W-1:0]    sel3_reg, a2_3_reg;

    // stage 4: partial products of the cross product square
    logic              s4_valid_reg;
    case_code_t        s4_code_reg;
    logic [SQ-1:0]     pp_hh_reg, pp_hl_reg, pp_ll_reg;
    logic [A2W-1:0]    sel4_reg, a2_4_reg;

    // stage 5: numerator and denominator
    logic              s5_valid_reg;
    case_code_t        s5_code_reg;
    logic [NUMW-1:0]   num_reg;
    logic [A2W-1:0]    den_reg;

    logic [M-1:0]      m_ux, m_uy, m_vx, m_vy, m_wx, m_wy;
    logic [SQ-1:0]     sq_ux, sq_uy, sq_vx, sq_vy, sq_wx, sq_wy;
    logic [A2W-1:0]    a2_next, b2_next, c2_next, sum_ac, sum_ab;
    logic [SQ-1:0]     cr_next;
    case_code_t        code_next;
    logic [A2W-1:0]    sel_next;
    logic [M-1:0]      cr_hi, cr_lo;
    logic [NUMW-1:0]   cr2_next;

    always_comb
    begin
        m_ux = ux_reg[M-1] ? M'(-ux_reg) : M'(ux_reg);
        m_uy = uy_reg[M-1] ? M'(-uy_reg) : M'(uy_reg);
        m_vx = vx_reg[M-1] ? M'(-vx_reg) : M'(vx_reg);
        m_vy = vy_reg[M-1] ? M'(-vy_reg) : M'(vy_reg);
        m_wx = wx_reg[M-1] ? M'(-wx_reg) : M'(wx_reg);
        m_wy = wy_reg[M-1] ? M'(-wy_reg) : M'(wy_reg);
        sq_ux = SQ'(m_ux) * SQ'(m_ux);
        sq_uy = SQ'(m_uy) * SQ'(m_uy);
        sq_vx = SQ'(m_vx) * SQ'(m_vx);
        sq_vy = SQ'(m_vy) * SQ'(m_vy);
        sq_wx = SQ'(m_wx) * SQ'(m_wx);
        sq_wy = SQ'(m_wy) * SQ'(m_wy);
        a2_next = A2W'(sq_ux) + A2W'(sq_uy);
        b2_next = A2W'(sq_vx) + A2W'(sq_vy);
        c2_next = A2W'(sq_wx) + A2W'(sq_wy);
    end

    always_comb
    begin
        sum_ac = a2_reg + c2_reg;
        sum_ab = a2_reg + b2_reg;
        if (mixed_reg)
            cr_next = t1_reg + t2_reg;
        else if (t1_reg >= t2_reg)
            cr_next = t1_reg - t2_reg;
        else
            cr_next = t2_reg - t1_reg;
        if ((a2_reg < A2W'(lim2_reg)) || (a2_reg == '0))
        begin
            code_next = CASE_DEGEN;
            sel_next  = b2_reg;
        end
        else if (b2_reg > sum_ac)
        begin
            code_next = CASE_END;
            sel_next  = c2_reg;
        end
        else if (c2_reg > sum_ab)
        begin
            code_next = CASE_START;
            sel_next  = b2_reg;
        end
        else
        begin
            code_next = CASE_PERP;
            sel_next  = b2_reg;
        end
    end

    assign cr_hi = cr_reg[SQ-1:M];
    assign cr_lo = cr_reg[M-1:0];

    assign cr2_next = (NUMW'(pp_hh_reg) << SQ) + (NUMW'(pp_hl_reg) << (M + 1))
                    + NUMW'(pp_ll_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg   <= M'(ex) - M'(sx);
        uy_reg   <= M'(ey) - M'(sy);
        vx_reg   <= M'(px) - M'(sx);
        vy_reg   <= M'(py) - M'(sy);
        wx_reg   <= M'(px) - M'(ex);
        wy_reg   <= M'(py) - M'(ey);
        lim1_reg <= LIMW'(msl) * LIMW'(msl);

        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        c2_reg    <= c2_next;
        t1_reg    <= SQ'(m_ux) * SQ'(m_vy);
        t2_reg    <= SQ'(m_uy) * SQ'(m_vx);
        mixed_reg <= (ux_reg[M-1] != vy_reg[M-1]) != (uy_reg[M-1] != vx_reg[M-1]);
        lim2_reg  <= lim1_reg;

        s3_code_reg <= code_next;
        cr_reg      <= cr_next;
        sel3_reg    <= sel_next;
        a2_3_reg    <= a2_reg;

        s4_code_reg <= s3_code_reg;
        pp_hh_reg   <= SQ'(cr_hi) * SQ'(cr_hi);
        pp_hl_reg   <= SQ'(cr_hi) * SQ'(cr_lo);
        pp_ll_reg   <= SQ'(cr_lo) * SQ'(cr_lo);
        sel4_reg    <= sel3_reg;
        a2_4_reg    <= a2_3_reg;

        s5_code_reg <= s4_code_reg;
        num_reg     <= (s4_code_reg == CASE_PERP) ? cr2_next : NUMW'(sel4_reg);
        den_reg     <= (s4_code_reg == CASE_PERP) ? a2_4_reg : A2W'(1);
    end

    assign out_valid = s5_valid_reg;
    assign out_code  = s5_code_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;

endmodule

// File: hdl/psd_div_cell.sv
// ----------------------------------------------------------------------------
// psd_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module psd_div_cell #(
    parameter int DEN_W  = 67,
    parameter int WORK_W = 67
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  psd_pkg::case_code_t in_code,
    input  logic [DEN_W-1:0]    in_rem,
    input  logic [WORK_W-1:0]   in_work,
    input  logic [DEN_W-1:0]    in_den,
    output logic                out_valid,
    output psd_pkg::case_code_t out_code,
    output logic [DEN_W-1:0]    out_rem,
    output logic [WORK_W-1:0]   out_work,
    output logic [DEN_W-1:0]    out_den
);
    import psd_pkg::*;

    logic             valid_reg;
    case_code_t       code_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [WORK_W-1:0] work_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {in_rem, in_work[WORK_W-1]};
    assign fits  = trial >= {1'b0, in_den};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= in_code;
        den_reg  <= in_den;
        rem_reg  <= fits ? DEN_W'(trial - {1'b0, in_den}) : DEN_W'(trial);
        work_reg <= {in_work[WORK_W-2:0], fits};
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_rem   = rem_reg;
    assign out_work  = work_reg;
    assign out_den   = den_reg;

endmodule

// File: hdl/psd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// one restoring square root step: one root bit per cell
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(
    parameter int ROOT_W = 34
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  psd_pkg::case_code_t   in_code,
    input  logic [ROOT_W+1:0]     in_rem,
    input  logic [ROOT_W-1:0]     in_root,
    input  logic [2*ROOT_W-1:0]   in_work,
    output logic                  out_valid,
    output psd_pkg::case_code_t   out_code,
    output logic [ROOT_W+1:0]     out_rem,
    output logic [ROOT_W-1:0]     out_root,
    output logic [2*ROOT_W-1:0]   out_work
);
    import psd_pkg::*;

    localparam int WW = 2 * ROOT_W;
    localparam int TW = ROOT_W + 4;

    logic              valid_reg;
    case_code_t        code_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [WW-1:0]     work_reg;
    logic [TW-1:0]     acc, probe;
    logic              fits;

    assign acc   = {in_rem, in_work[WW-1 -: 2]};
    assign probe = TW'({in_root, 2'b01});
    assign fits  = acc >= probe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= in_code;
        rem_reg  <= fits ? (ROOT_W+2)'(acc - probe) : (ROOT_W+2)'(acc);
        root_reg <= {in_root[ROOT_W-2:0], fits};
        work_reg <= {in_work[WW-3:0], 2'b00};
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_work  = work_reg;

endmodule

// File: hdl/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// shortest distance from a query point to a line segment, fixed point
// ----------------------------------------------------------------------------
//
// channel   signals                                   dir   handshake
// input     start, point_*, start_*, end_*            in    start & !busy
// result    done, distance, case_code                 out   one-cycle strobe
// config    cfg_wr_en, cfg_wr_data                    in    write on cfg_wr_en
//
// one word accepted every cycle, busy stays low; each word passes the
// front stages, then the division row (one quotient bit per cell) and
// then the square root row (one root bit per cell)
// reset clears the valid bits of every stage and loads min length 7
// the receiver cannot stall; results leave on the done strobe
//
module point_segment_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     point_x,
    input  logic signed [COORD_WIDTH-1:0]     point_y,
    input  logic signed [COORD_WIDTH-1:0]     start_x,
    input  logic signed [COORD_WIDTH-1:0]     start_y,
    input  logic signed [COORD_WIDTH-1:0]     end_x,
    input  logic signed [COORD_WIDTH-1:0]     end_y,
    input  logic                              cfg_wr_en,
    input  logic [psd_pkg::MSL_WIDTH-1:0]     cfg_wr_data,
    output logic                              done,
    output logic [psd_pkg::DIST_WIDTH-1:0]    distance,
    output psd_pkg::case_code_t               case_code
);
    import psd_pkg::*;

    localparam int M    = COORD_WIDTH + 1;
    localparam int A2W  = 2 * M + 1;     // squared length width, also quotient width
    localparam int NUMW = 4 * M;
    localparam int RW   = M + 1;         // root width
    localparam int SW   = 2 * RW;

    // min segment length register
    logic [MSL_WIDTH-1:0] msl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            msl_reg <= MSL_RESET;
        else if (cfg_wr_en)
            msl_reg <= cfg_wr_data;
    end

    // front stages: lengths, case pick, numerator and denominator
    logic            f_valid;
    case_code_t      f_code;
    logic [NUMW-1:0] f_num;
    logic [A2W-1:0]  f_den;

    psd_front #(
        .CW (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .px        (point_x),
        .py        (point_y),
        .sx        (start_x),
        .sy        (start_y),
        .ex        (end_x),
        .ey        (end_y),
        .msl       (msl_reg),
        .out_valid (f_valid),
        .out_code  (f_code),
        .out_num   (f_num),
        .out_den   (f_den)
    );

    // division row: quotient fits A2W bits, so the top numerator bits seed
    // the remainder and only the low A2W bits are walked
    logic           d_valid [0:A2W];
    case_code_t     d_code  [0:A2W];
    logic [A2W-1:0] d_rem   [0:A2W];
    logic [A2W-1:0] d_work  [0:A2W];
    logic [A2W-1:0] d_den   [0:A2W];

    assign d_valid[0] = f_valid;
    assign d_code[0]  = f_code;
    assign d_rem[0]   = A2W'(f_num[NUMW-1:A2W]);
    assign d_work[0]  = f_num[A2W-1:0];
    assign d_den[0]   = f_den;

    for (genvar i = 0; i < A2W; i++)
    begin : g_div
        psd_div_cell #(
            .DEN_W  (A2W),
            .WORK_W (A2W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (d_valid[i]),
            .in_code   (d_code[i]),
            .in_rem    (d_rem[i]),
            .in_work   (d_work[i]),
            .in_den    (d_den[i]),
            .out_valid (d_valid[i+1]),
            .out_code  (d_code[i+1]),
            .out_rem   (d_rem[i+1]),
            .out_work  (d_work[i+1]),
            .out_den   (d_den[i+1])
        );
    end

    // square root row, one root bit per cell, msb first
    logic            r_valid [0:RW];
    case_code_t      r_code  [0:RW];
    logic [RW+1:0]   r_rem   [0:RW];
    logic [RW-1:0]   r_root  [0:RW];
    logic [SW-1:0]   r_work  [0:RW];

    assign r_valid[0] = d_valid[A2W];
    assign r_code[0]  = d_code[A2W];
    assign r_rem[0]   = '0;
    assign r_root[0]  = '0;
    assign r_work[0]  = SW'(d_work[A2W]);

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .ROOT_W (RW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (r_valid[k]),
            .in_code   (r_code[k]),
            .in_rem    (r_rem[k]),
            .in_root   (r_root[k]),
            .in_work   (r_work[k]),
            .out_valid (r_valid[k+1]),
            .out_code  (r_code[k+1]),
            .out_rem   (r_rem[k+1]),
            .out_root  (r_root[k+1]),
            .out_work  (r_work[k+1])
        );
    end

    // fully pipelined, never holds off a word
    assign busy      = 1'b0;
    assign done      = r_valid[RW];
    assign case_code = r_code[RW];
    assign distance  = DIST_WIDTH'(r_root[RW]);

endmodule

// File: hdl/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// port level checks for point_segment_distance
// ----------------------------------------------------------------------------
module psd_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    localparam int LAT = 5 + (2 * COORD_WIDTH + 3) + (COORD_WIDTH + 2);

    // a word is never held off
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every accepted word gives one result
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing");

    // no result without an accepted word
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("unexpected result");

endmodule

bind point_segment_distance psd_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_psd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
